// File: src/poisson_disk_grid_check_insert_macros.svh
// assertion helpers shared by the grid check blocks
`ifndef POISSON_DISK_GRID_CHECK_INSERT_MACROS_SVH
`define POISSON_DISK_GRID_CHECK_INSERT_MACROS_SVH

// checked only outside reset
`define PDG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define PDG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/pdg_pkg.sv
package pdg_pkg;

  localparam int COORD_W   = 16;
  localparam int COUNT_W   = 13;
  localparam int CELL_W    = 6;
  localparam int DIM_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int ENTRY_W   = 1 + 2 * COORD_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [1:0] STATUS_CLOSE   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RANGE,
    ST_SCAN,
    ST_DRAIN,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic clear;
    logic issue;
    logic center;
  } dist_ctrl_t;

  typedef struct packed {
    logic close;
    logic center_valid;
  } dist_stat_t;

endpackage

// File: src/pdg_ram.sv
module pdg_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/pdg_div.sv
module pdg_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [pdg_pkg::COORD_W-1:0] num_a,
  input  logic [pdg_pkg::COORD_W-1:0] num_b,
  input  logic [pdg_pkg::COORD_W-1:0] den,
  output logic                   done,
  output logic [pdg_pkg::COORD_W-1:0] quo_a,
  output logic [pdg_pkg::COORD_W-1:0] quo_b
);

  import pdg_pkg::*;

  localparam int CNT_W = $clog2(COORD_W);

  logic               running;
  logic [CNT_W-1:0]   cnt;
  logic [COORD_W-1:0] rem_a, rem_b, den_r;
  logic [2*COORD_W-1:0] step_a, step_b;

  // one restoring step: returns {remainder, quotient}
  function automatic logic [2*COORD_W-1:0] div_step(
    input logic [COORD_W-1:0] rem,
    input logic [COORD_W-1:0] quo,
    input logic [COORD_W-1:0] d
  );
    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    trial = {rem, quo[COORD_W-1]};
    diff  = trial - {1'b0, d};
    if (trial >= {1'b0, d}) begin
      div_step = {diff[COORD_W-1:0], quo[COORD_W-2:0], 1'b1};
    end else begin
      div_step = {trial[COORD_W-1:0], quo[COORD_W-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    step_a = div_step(rem_a, quo_a, den_r);
    step_b = div_step(rem_b, quo_b, den_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(COORD_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_a <= '0;
      rem_b <= '0;
      quo_a <= num_a;
      quo_b <= num_b;
      den_r <= den;
    end else if (running) begin
      {rem_a, quo_a} <= step_a;
      {rem_b, quo_b} <= step_b;
    end
  end

endmodule

// File: src/pdg_dist.sv
`include "poisson_disk_grid_check_insert_macros.svh"

module pdg_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  pdg_pkg::dist_ctrl_t         ctrl,
  input  logic [pdg_pkg::ENTRY_W-1:0] rdata,
  input  logic [pdg_pkg::COORD_W-1:0] cand_x,
  input  logic [pdg_pkg::COORD_W-1:0] cand_y,
  input  logic [2*pdg_pkg::COORD_W-1:0] r2,
  output pdg_pkg::dist_stat_t         stat
);

  import pdg_pkg::*;

  localparam int SQ_W = 2 * COORD_W;

  logic               s1_v, s1_c, s2_v;
  logic [COORD_W-1:0] px, py, dx, dy;
  logic [SQ_W-1:0]    sqx, sqy;
  logic [SQ_W:0]      dsum;

  assign px = rdata[2*COORD_W-1:COORD_W];
  assign py = rdata[COORD_W-1:0];

  always_comb begin
    dx   = (px >= cand_x) ? px - cand_x : cand_x - px;
    dy   = (py >= cand_y) ? py - cand_y : cand_y - py;
    dsum = {1'b0, sqx} + {1'b0, sqy};
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      s1_v <= 1'b0;
      s1_c <= 1'b0;
      s2_v <= 1'b0;
      stat <= '0;
    end else begin
      s1_v <= ctrl.issue;
      s1_c <= ctrl.center;
      s2_v <= s1_v && rdata[ENTRY_W-1];
      if (s1_v && s1_c) begin
        stat.center_valid <= rdata[ENTRY_W-1];
      end
      if (s2_v && (dsum < {1'b0, r2})) begin
        stat.close <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sqx <= SQ_W'(dx) * SQ_W'(dx);
    sqy <= SQ_W'(dy) * SQ_W'(dy);
  end

  `PDG_ASSERT(a_clear_close, ctrl.clear |=> !stat.close, "close flag survived a clear")
  `PDG_ASSERT(a_clear_center, ctrl.clear |=> !stat.center_valid, "center flag survived a clear")
  `PDG_ASSERT_ALWAYS(a_rst_pipe, rst |=> (!s1_v && !s2_v), "scan pipeline live after reset")

endmodule

// File: src/poisson_disk_grid_check_insert.sv
// channel  direction  handshake          fields
// request  in         start, busy        cand_x, cand_y
// result   out        done (one cycle)   status, cell_col, cell_row, stored_count
// config   in         cfg_we             cfg_index, cfg_data
//
// outside the area the result comes in the cycle after acceptance; outside the grid it
// follows the 16 bit-serial divider steps, the divider done and the range state;
// otherwise those steps are followed by a scan of N = 1..25 cells of the clipped 5x5
// block, one grid read per cell, a drain of the distance pipeline and the write state
// after reset all GRID_COLS*GRID_ROWS grid entries are cleared one entry a cycle,
// with busy high and config writes taken; busy drops with done, receiver cannot stall
`include "poisson_disk_grid_check_insert_macros.svh"

module poisson_disk_grid_check_insert #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pdg_pkg::COORD_W-1:0]   cand_x,
  input  logic [pdg_pkg::COORD_W-1:0]   cand_y,
  output logic                          done,
  output logic [1:0]                    status,
  output logic [pdg_pkg::CELL_W-1:0]    cell_col,
  output logic [pdg_pkg::CELL_W-1:0]    cell_row,
  output logic [pdg_pkg::COUNT_W-1:0]   stored_count,
  input  logic                          cfg_we,
  input  logic [pdg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pdg_pkg::COORD_W-1:0]   cfg_data
);

  import pdg_pkg::*;

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIW   = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int RIW   = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CNW   = ($clog2(GRID_COLS + 1) > DIM_W) ? $clog2(GRID_COLS + 1) : DIM_W;
  localparam int RNW   = ($clog2(GRID_ROWS + 1) > DIM_W) ? $clog2(GRID_ROWS + 1) : DIM_W;
  localparam int R2_W  = 2 * COORD_W;

  // configuration
  logic [COORD_W-1:0] area_width, area_height, min_radius, cell_size;
  logic [DIM_W-1:0]   grid_cols, grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= 16'd1024;
      area_height <= 16'd1024;
      min_radius  <= 16'd22;
      cell_size   <= 16'd16;
      grid_cols   <= 7'd64;
      grid_rows   <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_WIDTH:  area_width  <= cfg_data;
        REG_AREA_HEIGHT: area_height <= cfg_data;
        REG_MIN_RADIUS:  min_radius  <= cfg_data;
        REG_CELL_SIZE:   cell_size   <= cfg_data;
        REG_GRID_COLS:   grid_cols   <= cfg_data[DIM_W-1:0];
        REG_GRID_ROWS:   grid_rows   <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  logic [AW-1:0]      clr_addr;
  logic [COORD_W-1:0] x_r, y_r;
  logic [R2_W-1:0]    r2;
  logic [CIW-1:0]     col_r, c_scan, c1_r;
  logic [RIW-1:0]     row_r, r_scan, r0_r, r1_r;
  logic               drain;
  logic [COUNT_W-1:0] point_total;

  logic [COORD_W-1:0] div_den, col_q, row_q;
  logic               div_start, div_done;
  logic [CNW-1:0]     cols_lim;
  logic [RNW-1:0]     rows_lim;
  logic               outside_in, out_grid, scan_last, count_inc;
  logic [CNW:0]       ce, c0e, c1e, cmax;
  logic [RNW:0]       re, r0e, r1e, rmax;
  logic [AW-1:0]      scan_addr, ins_addr;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
  dist_ctrl_t         dctrl;
  dist_stat_t         dstat;

  always_comb begin
    div_den = (cell_size == '0) ? COORD_W'(1) : cell_size;

    if (grid_cols == '0) begin
      cols_lim = CNW'(1);
    end else if (CNW'(grid_cols) > CNW'(GRID_COLS)) begin
      cols_lim = CNW'(GRID_COLS);
    end else begin
      cols_lim = CNW'(grid_cols);
    end
    if (grid_rows == '0) begin
      rows_lim = RNW'(1);
    end else if (RNW'(grid_rows) > RNW'(GRID_ROWS)) begin
      rows_lim = RNW'(GRID_ROWS);
    end else begin
      rows_lim = RNW'(grid_rows);
    end

    outside_in = (cand_x >= area_width) || (cand_y >= area_height);
    out_grid   = (col_q >= COORD_W'(cols_lim)) || (row_q >= COORD_W'(rows_lim));

    // clipped 5x5 block around the cell
    ce   = (CNW + 1)'(col_q[CIW-1:0]);
    re   = (RNW + 1)'(row_q[RIW-1:0]);
    cmax = (CNW + 1)'(cols_lim) - (CNW + 1)'(1);
    rmax = (RNW + 1)'(rows_lim) - (RNW + 1)'(1);
    c0e  = (ce >= (CNW + 1)'(2)) ? ce - (CNW + 1)'(2) : '0;
    r0e  = (re >= (RNW + 1)'(2)) ? re - (RNW + 1)'(2) : '0;
    c1e  = (ce + (CNW + 1)'(2) < cmax) ? ce + (CNW + 1)'(2) : cmax;
    r1e  = (re + (RNW + 1)'(2) < rmax) ? re + (RNW + 1)'(2) : rmax;

    scan_last = (c_scan == c1_r) && (r_scan == r1_r);
    scan_addr = AW'(r_scan) * AW'(GRID_COLS) + AW'(c_scan);
    ins_addr  = AW'(row_r) * AW'(GRID_COLS) + AW'(col_r);
    count_inc = !dstat.center_valid && (point_total != COUNT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = clr_addr;
    ram_wdata  = '0;
    div_start  = 1'b0;
    dctrl      = '0;
    case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && !outside_in) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (out_grid) begin
          state_next = ST_IDLE;
        end else begin
          dctrl.clear = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        dctrl.issue  = 1'b1;
        dctrl.center = (c_scan == col_r) && (r_scan == row_r);
        if (scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!dstat.close) begin
          ram_we    = 1'b1;
          ram_waddr = ins_addr;
          ram_wdata = {1'b1, x_r, y_r};
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy = (state != ST_IDLE);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      done        <= 1'b0;
      point_total <= '0;
      clr_addr    <= '0;
      drain       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: clr_addr <= clr_addr + AW'(1);
        ST_IDLE:  done <= start && outside_in;
        ST_RANGE: done <= out_grid;
        ST_SCAN:  drain <= 1'b0;
        ST_DRAIN: drain <= 1'b1;
        ST_WRITE: begin
          done <= 1'b1;
          if (!dstat.close && count_inc) begin
            point_total <= point_total + COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        x_r          <= cand_x;
        y_r          <= cand_y;
        r2           <= R2_W'(min_radius) * R2_W'(min_radius);
        status       <= STATUS_OUTSIDE;
        cell_col     <= '0;
        cell_row     <= '0;
        stored_count <= point_total;
      end
      ST_RANGE: begin
        col_r        <= col_q[CIW-1:0];
        row_r        <= row_q[RIW-1:0];
        c_scan       <= c0e[CIW-1:0];
        r_scan       <= r0e[RIW-1:0];
        r0_r         <= r0e[RIW-1:0];
        c1_r         <= c1e[CIW-1:0];
        r1_r         <= r1e[RIW-1:0];
        status       <= STATUS_OUTSIDE;
        cell_col     <= '0;
        cell_row     <= '0;
        stored_count <= point_total;
      end
      ST_SCAN: begin
        if (r_scan == r1_r) begin
          r_scan <= r0_r;
          c_scan <= c_scan + CIW'(1);
        end else begin
          r_scan <= r_scan + RIW'(1);
        end
      end
      ST_WRITE: begin
        cell_col <= CELL_W'(col_r);
        cell_row <= CELL_W'(row_r);
        if (dstat.close) begin
          status       <= STATUS_CLOSE;
          stored_count <= point_total;
        end else begin
          status       <= STATUS_OK;
          stored_count <= point_total + COUNT_W'(count_inc);
        end
      end
      default: ;
    endcase
  end

  pdg_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num_a (cand_x),
    .num_b (cand_y),
    .den   (div_den),
    .done  (div_done),
    .quo_a (col_q),
    .quo_b (row_q)
  );

  pdg_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_addr),
    .rdata (ram_rdata)
  );

  pdg_dist u_dist (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (dctrl),
    .rdata  (ram_rdata),
    .cand_x (x_r),
    .cand_y (y_r),
    .r2     (r2),
    .stat   (dstat)
  );

  `PDG_ASSERT(a_we_state, ram_we |-> (state == ST_WRITE || state == ST_CLEAR),
              "grid write outside clear or insert")
  `PDG_ASSERT(a_count_hold, (done && status != STATUS_OK) |-> $stable(point_total),
              "count moved on a rejected request")
  `PDG_ASSERT(a_count_step, (!$past(rst) && point_total != $past(point_total)) |->
              (point_total == $past(point_total) + COUNT_W'(1)), "count jumped")
  `PDG_ASSERT(a_count_out, done |-> (stored_count == point_total),
              "reported count differs from stored count")

endmodule
